// ===== design/fcbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fcbs_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned PosW   = 29;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned QDepth = 2;

  typedef enum logic {
    KIND_FREE      = 1'b0,
    KIND_SHORTFALL = 1'b1
  } result_kind_e;

  // register select taken from paddr bit 2
  typedef enum logic {
    REG_REQUIRED = 1'b0,
    REG_CLUSTERS = 1'b1
  } reg_idx_e;

  // one classified bitmap byte: bit k of free_mask is cluster offset 8*pos+k
  typedef struct packed {
    logic [7:0]      free_mask;
    logic [PosW-1:0] pos;
    logic            last_byte;
    logic            scan_start;
  } scan_entry_t;

endpackage

`default_nettype wire

// ===== design/fcbs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fcbs_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [7:0]               bitmap_byte_i,
  input  logic                     final_byte_i,
  input  logic [31:0]              cluster_count_i,
  output fcbs_pkg::scan_entry_t    entry_o
);
  import fcbs_pkg::*;

  logic [PosW-1:0] byte_position_q, byte_position_d;
  logic            scan_active_q, scan_active_d;

  logic [PosW-1:0] pos;
  logic [DataW:0]  diff;
  logic            any_left;
  logic [7:0]      in_range;
  logic [7:0]      free_mask;

  assign pos  = scan_active_q ? byte_position_q : '0;
  // clusters still covered from the first bit of this byte on
  assign diff = {1'b0, cluster_count_i} - {1'b0, pos, 3'b000};
  assign any_left = !diff[DataW] && (diff[DataW-1:0] != '0);

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      in_range[k]  = any_left && ((diff[DataW-1:3] != '0) || (diff[2:0] > 3'(k)));
      free_mask[k] = in_range[k] && !bitmap_byte_i[7-k];
    end
  end

  assign entry_o.free_mask  = free_mask;
  assign entry_o.pos        = pos;
  assign entry_o.last_byte  = final_byte_i;
  assign entry_o.scan_start = !scan_active_q;

  always_comb begin
    byte_position_d = byte_position_q;
    scan_active_d   = scan_active_q;
    if (accept_i) begin
      byte_position_d = pos + 1'b1;
      scan_active_d   = !final_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_position_q <= '0;
      scan_active_q   <= 1'b0;
    end else begin
      byte_position_q <= byte_position_d;
      scan_active_q   <= scan_active_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/fcbs_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fcbs_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  fcbs_pkg::scan_entry_t push_entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output fcbs_pkg::scan_entry_t head_o
);
  import fcbs_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  scan_entry_t     slot_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(QDepth - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/fcbs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fcbs_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  fcbs_pkg::scan_entry_t head_i,
  output logic                  pop_o,
  input  logic [31:0]           required_count_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  result_kind_o,
  output logic [31:0]           value_o,
  output logic                  last_o
);
  import fcbs_pkg::*;

  logic              busy_q, busy_d;
  logic [7:0]        mask_q, mask_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              fin_q, fin_d;
  logic [DataW-1:0]  rem_q, rem_d;

  logic              out_valid_q, out_valid_d;
  result_kind_e      kind_q, kind_d;
  logic [DataW-1:0]  value_q, value_d;
  logic              last_q, last_d;

  logic [7:0]        cand;
  logic [2:0]        sel_k;
  logic [DataW-1:0]  rem_dec;
  logic [7:0]        mask_clr;
  logic              step, emit, emit_last, emit_free, done;

  assign cand     = mask_q & {8{rem_q != '0}};
  assign rem_dec  = rem_q - 1'b1;
  assign mask_clr = mask_q & ~(8'b1 << sel_k);
  assign step     = busy_q && (!out_valid_q || out_ready_i);

  // lowest set bit is the lowest cluster number
  always_comb begin
    sel_k = '0;
    for (int k = 7; k >= 0; k--) begin
      if (cand[k]) begin
        sel_k = 3'(k);
      end
    end
  end

  always_comb begin
    emit      = 1'b0;
    emit_free = 1'b0;
    emit_last = 1'b0;
    kind_d    = kind_q;
    value_d   = value_q;
    if (cand != '0) begin
      emit      = 1'b1;
      emit_free = 1'b1;
      kind_d    = KIND_FREE;
      value_d   = {pos_q, sel_k} + DataW'(2);
      emit_last = !((rem_dec != '0) && ((mask_clr != '0) || fin_q));
    end else if (fin_q && (rem_q != '0)) begin
      emit      = 1'b1;
      kind_d    = KIND_SHORTFALL;
      value_d   = rem_q;
      emit_last = 1'b1;
    end
    done  = !emit || emit_last;
    pop_o = head_valid_i && (!busy_q || (step && done));

    busy_d = busy_q;
    mask_d = mask_q;
    pos_d  = pos_q;
    fin_d  = fin_q;
    rem_d  = rem_q;
    if (step) begin
      if (emit_free) begin
        rem_d  = rem_dec;
        mask_d = mask_clr;
      end
      if (done) begin
        busy_d = 1'b0;
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      mask_d = head_i.free_mask;
      pos_d  = head_i.pos;
      fin_d  = head_i.last_byte;
      if (head_i.scan_start) begin
        rem_d = required_count_i;
      end
    end

    last_d      = last_q;
    out_valid_d = out_valid_q;
    if (step && emit) begin
      out_valid_d = 1'b1;
      last_d      = emit_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (!(step && emit)) begin
      kind_d  = kind_q;
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q  <= mask_d;
    pos_q   <= pos_d;
    fin_q   <= fin_d;
    kind_q  <= kind_d;
    value_q <= value_d;
    last_q  <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign value_o       = value_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

// ===== design/free_cluster_bitmap_scan_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Free cluster search over an allocation bitmap fed one byte per transaction (MSB is the
// lowest cluster, 1 means allocated). The front end takes a byte in every cycle in which
// its two-entry queue has room, masks out clusters at or beyond cluster_count and queues
// the byte; the back end then hands out one result per cycle while the result output is
// not stalled, and a byte causes from 0 to 9 results: up to eight free cluster numbers
// plus a shortfall report after the final byte. A byte passes through the queue and the
// back end's byte registers before its results are registered. required_count is sampled
// at the first byte of a scan, cluster_count when each byte is taken; write registers
// only while the block is idle.
module free_cluster_bitmap_scan_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // apb configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [fcbs_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // bitmap bytes
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                bitmap_byte_i,
  input  logic                      final_byte_i,
  // results
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      result_kind_o,
  output logic [31:0]               value_o,
  output logic                      last_o
);
  import fcbs_pkg::*;

  logic [DataW-1:0] required_count_q, required_count_d;
  logic [DataW-1:0] cluster_count_q, cluster_count_d;
  reg_idx_e         reg_sel;
  logic             cfg_write;

  scan_entry_t      push_entry, head;
  logic             q_full, q_empty, pop, accept;

  assign pready    = 1'b1;
  assign reg_sel   = reg_idx_e'(paddr[2]);
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    required_count_d = required_count_q;
    cluster_count_d  = cluster_count_q;
    if (cfg_write) begin
      case (reg_sel)
        REG_REQUIRED: required_count_d = pwdata;
        REG_CLUSTERS: cluster_count_d  = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_REQUIRED: prdata = required_count_q;
      REG_CLUSTERS: prdata = cluster_count_q;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      required_count_q <= '0;
      cluster_count_q  <= '0;
    end else begin
      required_count_q <= required_count_d;
      cluster_count_q  <= cluster_count_d;
    end
  end

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && !q_full;

  fcbs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .bitmap_byte_i   (bitmap_byte_i),
    .final_byte_i    (final_byte_i),
    .cluster_count_i (cluster_count_q),
    .entry_o         (push_entry)
  );

  fcbs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .empty_o      (q_empty),
    .head_o       (head)
  );

  fcbs_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (!q_empty),
    .head_i           (head),
    .pop_o            (pop),
    .required_count_i (required_count_q),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .result_kind_o    (result_kind_o),
    .value_o          (value_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire

// ===== design/fcbs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fcbs_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fcbs_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic [31:0]                prdata,
  input  logic                       pready,
  input  logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  logic                       result_kind_o,
  input  logic [31:0]                value_o,
  input  logic                       last_o
);
  import fcbs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o) && $stable(last_o)
      && $stable(result_kind_o))
    else $error("result changed while stalled");

  // a shortfall closes the byte's results and is never zero
  a_short_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KIND_SHORTFALL) |-> last_o && (value_o != '0))
    else $error("bad shortfall result");

  // a register read back straight after a write returns the written data
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready ##1 psel && !pwrite && (paddr[2] == $past(paddr[2]))
      |-> prdata == $past(pwdata))
    else $error("register readback mismatch");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind free_cluster_bitmap_scan_unit fcbs_checker u_fcbs_checker (.*);

`default_nettype wire
